FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check clocked on clk, off while rst_n is low.
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check clocked on clk, active during reset as well.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/cbs_pkg.sv
`timescale 1ns / 1ps
package cbs_pkg;

    localparam int NUM_POINTS = 7;

    typedef logic [2:0] point_idx_t;

    localparam point_idx_t FIRST_POINT = 3'd0;
    localparam point_idx_t LAST_POINT  = 3'd6;

    typedef struct packed {
        logic       valid;
        logic       last;
        point_idx_t index;
    } out_stat_t;

endpackage

FILE: hw/rtl/cubic_bezier_split.sv
`timescale 1ns / 1ps
// Channel   Handshake            Fields
// input     start / busy         start_x/y, ctrl_a_x/y, ctrl_b_x/y, end_x/y, split_t
// result    point_valid (strobe) point_x, point_y, point_index, last
//
// An item is taken when start is high and busy low; busy then stays high while the
// hold count runs down from NUM_POINTS - 1, pacing items to the seven-point output.
// The x and y lanes run three registered interpolation levels; the points then pass
// the merge shift line and come out one point per cycle.
// Reset clears the valid pipe, the busy count and the output sequencer.
// The receiver cannot stall; a new item's points follow the previous ones directly.
module cubic_bezier_split #(
    parameter int COORD_WIDTH = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] ctrl_a_x,
    input  logic signed [COORD_WIDTH-1:0] ctrl_a_y,
    input  logic signed [COORD_WIDTH-1:0] ctrl_b_x,
    input  logic signed [COORD_WIDTH-1:0] ctrl_b_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic        [T_FRAC_BITS:0]   split_t,
    output logic                          point_valid,
    output logic signed [COORD_WIDTH-1:0] point_x,
    output logic signed [COORD_WIDTH-1:0] point_y,
    output logic        [2:0]             point_index,
    output logic                          last
);

    localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    logic                          accept;
    logic [T_FRAC_BITS:0]          t_sat;
    logic [2:0]                    stage_vld_reg;
    logic [2:0]                    hold_reg;
    logic signed [COORD_WIDTH-1:0] xs [cbs_pkg::NUM_POINTS];
    logic signed [COORD_WIDTH-1:0] ys [cbs_pkg::NUM_POINTS];
    cbs_pkg::out_stat_t            stat;

    assign accept = start && !busy;
    assign busy   = (hold_reg != 3'd0);
    // clamp the parameter to 1.0
    assign t_sat  = (split_t > T_ONE) ? T_ONE : split_t;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 3'b000;
            hold_reg      <= 3'd0;
        end
        else
        begin
            stage_vld_reg <= {stage_vld_reg[1:0], accept};
            if (accept)
            begin
                hold_reg <= 3'(cbs_pkg::NUM_POINTS - 1);
            end
            else if (hold_reg != 3'd0)
            begin
                hold_reg <= hold_reg - 3'd1;
            end
        end
    end

    cbs_lane #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_lane_x
    (
        .clk (clk),
        .load(accept),
        .p0  (start_x),
        .p1  (ctrl_a_x),
        .p2  (ctrl_b_x),
        .p3  (end_x),
        .t   (t_sat),
        .pts (xs)
    );

    cbs_lane #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_lane_y
    (
        .clk (clk),
        .load(accept),
        .p0  (start_y),
        .p1  (ctrl_a_y),
        .p2  (ctrl_b_y),
        .p3  (end_y),
        .t   (t_sat),
        .pts (ys)
    );

    cbs_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (stage_vld_reg[2]),
        .xs     (xs),
        .ys     (ys),
        .point_x(point_x),
        .point_y(point_y),
        .stat   (stat)
    );

    assign point_valid = stat.valid;
    assign point_index = stat.index;
    assign last        = stat.last;

endmodule

FILE: hw/rtl/cbs_lerp.sv
`timescale 1ns / 1ps
module cbs_lerp #(
    parameter int COORD_WIDTH = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  logic signed [COORD_WIDTH-1:0] a,
    input  logic signed [COORD_WIDTH-1:0] b,
    input  logic        [T_FRAC_BITS:0]   t,
    output logic signed [COORD_WIDTH-1:0] y
);

    localparam int PW = COORD_WIDTH + T_FRAC_BITS + 3;

    logic signed [COORD_WIDTH:0]   diff;
    logic signed [T_FRAC_BITS+1:0] t_s;
    logic signed [PW-1:0]          prod;
    logic signed [PW-1:0]          shifted;

    assign diff    = {b[COORD_WIDTH-1], b} - {a[COORD_WIDTH-1], a};
    assign t_s     = {1'b0, t};
    assign prod    = PW'(diff) * PW'(t_s);
    // arithmetic shift rounds toward minus infinity
    assign shifted = prod >>> T_FRAC_BITS;
    // the interpolated value lies between a and b, so the low bits are exact
    assign y       = a + shifted[COORD_WIDTH-1:0];

endmodule

FILE: hw/rtl/cbs_lane.sv
`timescale 1ns / 1ps
module cbs_lane #(
    parameter int COORD_WIDTH = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic signed [COORD_WIDTH-1:0] p0,
    input  logic signed [COORD_WIDTH-1:0] p1,
    input  logic signed [COORD_WIDTH-1:0] p2,
    input  logic signed [COORD_WIDTH-1:0] p3,
    input  logic        [T_FRAC_BITS:0]   t,
    output logic signed [COORD_WIDTH-1:0] pts [cbs_pkg::NUM_POINTS]
);

    // level one
    logic signed [COORD_WIDTH-1:0] a1_next, b1_next, c1_next;
    logic signed [COORD_WIDTH-1:0] s1_p0_reg, s1_p3_reg;
    logic signed [COORD_WIDTH-1:0] s1_a1_reg, s1_b1_reg, s1_c1_reg;
    logic        [T_FRAC_BITS:0]   s1_t_reg;

    // level two
    logic signed [COORD_WIDTH-1:0] a2_next, b2_next;
    logic signed [COORD_WIDTH-1:0] s2_p0_reg, s2_p3_reg, s2_a1_reg, s2_c1_reg;
    logic signed [COORD_WIDTH-1:0] s2_a2_reg, s2_b2_reg;
    logic        [T_FRAC_BITS:0]   s2_t_reg;

    // level three
    logic signed [COORD_WIDTH-1:0] m_next;
    logic signed [COORD_WIDTH-1:0] s3_reg [cbs_pkg::NUM_POINTS];

    cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_a1
    (
        .a(p0), .b(p1), .t(t), .y(a1_next)
    );
    cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_b1
    (
        .a(p1), .b(p2), .t(t), .y(b1_next)
    );
    cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_c1
    (
        .a(p2), .b(p3), .t(t), .y(c1_next)
    );

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_p0_reg <= p0;
            s1_p3_reg <= p3;
            s1_a1_reg <= a1_next;
            s1_b1_reg <= b1_next;
            s1_c1_reg <= c1_next;
            s1_t_reg  <= t;
        end
    end

    cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_a2
    (
        .a(s1_a1_reg), .b(s1_b1_reg), .t(s1_t_reg), .y(a2_next)
    );
    cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_b2
    (
        .a(s1_b1_reg), .b(s1_c1_reg), .t(s1_t_reg), .y(b2_next)
    );

    always_ff @(posedge clk)
    begin
        s2_p0_reg <= s1_p0_reg;
        s2_p3_reg <= s1_p3_reg;
        s2_a1_reg <= s1_a1_reg;
        s2_c1_reg <= s1_c1_reg;
        s2_a2_reg <= a2_next;
        s2_b2_reg <= b2_next;
        s2_t_reg  <= s1_t_reg;
    end

    cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_lerp_m
    (
        .a(s2_a2_reg), .b(s2_b2_reg), .t(s2_t_reg), .y(m_next)
    );

    // order: start, left controls, split point, right controls, end
    always_ff @(posedge clk)
    begin
        s3_reg[0] <= s2_p0_reg;
        s3_reg[1] <= s2_a1_reg;
        s3_reg[2] <= s2_a2_reg;
        s3_reg[3] <= m_next;
        s3_reg[4] <= s2_b2_reg;
        s3_reg[5] <= s2_c1_reg;
        s3_reg[6] <= s2_p3_reg;
    end

    assign pts = s3_reg;

endmodule

FILE: hw/rtl/cbs_merge.sv
`timescale 1ns / 1ps
module cbs_merge #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic signed [COORD_WIDTH-1:0] xs [cbs_pkg::NUM_POINTS],
    input  logic signed [COORD_WIDTH-1:0] ys [cbs_pkg::NUM_POINTS],
    output logic signed [COORD_WIDTH-1:0] point_x,
    output logic signed [COORD_WIDTH-1:0] point_y,
    output cbs_pkg::out_stat_t            stat
);

    logic signed [COORD_WIDTH-1:0] x_reg [cbs_pkg::NUM_POINTS];
    logic signed [COORD_WIDTH-1:0] y_reg [cbs_pkg::NUM_POINTS];
    cbs_pkg::point_idx_t           idx_reg;
    logic                          active_reg;

    // shift line: the head entry is the point on the ports
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= xs;
            y_reg <= ys;
        end
        else
        begin
            for (int i = 0; i < cbs_pkg::NUM_POINTS - 1; i++)
            begin
                x_reg[i] <= x_reg[i+1];
                y_reg[i] <= y_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= cbs_pkg::FIRST_POINT;
            active_reg <= 1'b0;
        end
        else if (load)
        begin
            idx_reg    <= cbs_pkg::FIRST_POINT;
            active_reg <= 1'b1;
        end
        else if (active_reg)
        begin
            if (idx_reg == cbs_pkg::LAST_POINT)
            begin
                idx_reg    <= cbs_pkg::FIRST_POINT;
                active_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    assign point_x    = x_reg[0];
    assign point_y    = y_reg[0];
    assign stat.valid = active_reg;
    assign stat.index = idx_reg;
    assign stat.last  = active_reg && (idx_reg == cbs_pkg::LAST_POINT);

endmodule

FILE: hw/rtl/cbs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       point_valid,
    input logic [2:0] point_index,
    input logic       last
);

    `ASSERT_RST(a_last_on_final, last |-> (point_valid && point_index == cbs_pkg::LAST_POINT), "last without final point")
    `ASSERT_RST(a_run_continues, (point_valid && point_index != cbs_pkg::LAST_POINT) |=> (point_valid && point_index == $past(point_index) + 3'd1), "point run broken")
    `ASSERT_RST(a_busy_after_take, (start && !busy) |=> busy, "busy not raised after item taken")
    `ASSERT_RST(a_first_point_latency, (start && !busy) |-> ##4 (point_valid && point_index == cbs_pkg::FIRST_POINT), "first point not on time")

endmodule

bind cubic_bezier_split cbs_checker u_cbs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .point_valid(point_valid),
    .point_index(point_index),
    .last       (last)
);
